// File: rtl/medc_pkg.sv
// Package with the constants and types of the elevator group dispatcher.
`timescale 1ns / 1ps
package medc_pkg;

  localparam int unsigned Elevators    = 4;
  localparam int unsigned Floors       = 16;
  localparam int unsigned PendingDepth = 16;
  localparam int unsigned CarW         = 2;
  localparam int unsigned FloorW       = 4;
  localparam int unsigned PendW        = 4;
  localparam int unsigned UsedW        = 5;
  localparam int unsigned MemDepth     = Elevators * PendingDepth;
  localparam int unsigned MemAw        = 6;
  localparam int unsigned RpfDepth     = Elevators * Floors;
  localparam int unsigned EntryW       = 16;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegActElev = 2'd0;
  localparam logic [1:0] RegActFlr  = 2'd1;
  localparam logic [1:0] RegIdleBon = 2'd2;
  localparam logic [1:0] RegDirBon  = 2'd3;

  // Heading codes.
  localparam logic [1:0] HeadNone = 2'd0;
  localparam logic [1:0] HeadUp   = 2'd1;
  localparam logic [1:0] HeadDown = 2'd2;

  // Motion codes.
  localparam logic [1:0] MotIdle = 2'd0;
  localparam logic [1:0] MotUp   = 2'd1;
  localparam logic [1:0] MotDown = 2'd2;
  localparam logic [1:0] MotDoor = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StScore,
    StQueue,
    StCarStart,
    StBoardRd,
    StBoardChk,
    StBoardWr,
    StDropRd,
    StDropWr,
    StScan,
    StOut
  } state_e;

endpackage

// File: rtl/medc_ram.sv
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
module medc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/multi_elevator_dispatch_controller_core.sv
// Top level of the elevator group dispatcher: sequencer, car state and memories.
//
// Channel  Direction  Payload
// s_axis   in         tdata: req_from, req_to, req_id; tuser: req_valid
// m_axis   out        tdata: car fields; tuser: assigned_car, request_taken; tlast: last_car
// cfg      in         index 2 bits, data 5 bits
//
// A tick is accepted and, if it carries a request, scored car by car and queued; then
// each active car passes a start step, boarding when it has a pickup at its floor (a read
// and a check per pending entry examined, plus a write per rider boarding), the dropoff,
// a floor-by-floor scan that may turn before it decides, and the result beat. The shared
// subtract/compare unit and the single read port of the memories keep these steps serial.
// Reset clears all car state at once; rider counts use valid bits per entry.
// A stalled result holds the sequencer; s_axis_tready is high only when idle.
`timescale 1ns / 1ps
module multi_elevator_dispatch_controller_core
  import medc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // req_from[3:0], req_to[7:4], req_id[15:8]
  input  logic        s_axis_tuser,  // req_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // car_index, car_floor, car_motion, car_heading,
                                     // riders_aboard, riders_boarded, riders_left
  output logic [2:0]  m_axis_tuser,  // assigned_car[1:0], request_taken[2]
  output logic        m_axis_tlast,  // last_car
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  // Configuration registers.
  logic [2:0] act_elev_q;
  logic [4:0] act_flr_q;
  logic [3:0] idle_bon_q, dir_bon_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_elev_q <= 3'd2;
      act_flr_q  <= 5'd6;
      idle_bon_q <= 4'd5;
      dir_bon_q  <= 4'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegActElev: act_elev_q <= cfg_data_i[2:0];
        RegActFlr:  act_flr_q  <= cfg_data_i;
        RegIdleBon: idle_bon_q <= cfg_data_i[3:0];
        RegDirBon:  dir_bon_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamped counts of cars and floors.
  logic [2:0] ne;
  logic [4:0] nf;
  always_comb begin
    ne = act_elev_q;
    if (ne == 3'd0) ne = 3'd1;
    if (ne > 3'(Elevators)) ne = 3'(Elevators);
    nf = act_flr_q;
    if (nf < 5'd2) nf = 5'd2;
    if (nf > 5'(Floors)) nf = 5'(Floors);
  end

  // Car state.
  logic [FloorW-1:0] floor_q   [Elevators];
  logic [1:0]        head_q    [Elevators];
  logic              idle_q    [Elevators];
  logic [5:0]        aboard_q  [Elevators];
  logic [Floors-1:0] pick_q    [Elevators];
  logic [Floors-1:0] drop_q    [Elevators];
  logic [UsedW-1:0]  used_q    [Elevators];
  logic [RpfDepth-1:0] rpf_vld_q;

  // Sequencer registers.
  state_e state_q, state_d;
  logic [CarW-1:0]   car_q;
  logic [CarW-1:0]   best_q;
  logic signed [6:0] best_s_q;
  logic              rvalid_q, taken_q;
  logic [3:0]        rfrom_q, rto_q;
  logic [7:0]        rid_q;
  logic [UsedW-1:0]  rd_q, wr_q;
  logic [1:0]        motion_q;
  logic [4:0]        boarded_q;
  logic [5:0]        left_q;
  logic [4:0]        scan_q;
  logic              scan_dir_q, scan_pass_q;
  logic              found_q;
  logic [FloorW-1:0] ns_q;
  logic [3:0]        bto_q;

  // Pending entry memory.
  logic              pe_we;
  logic [MemAw-1:0]  pe_waddr, pe_raddr;
  logic [EntryW-1:0] pe_wdata, pe_rdata;

  medc_ram #(.Width(EntryW), .Depth(MemDepth)) u_pend (
    .clk_i  (clk_i),
    .we_i   (pe_we),
    .waddr_i(pe_waddr),
    .wdata_i(pe_wdata),
    .raddr_i(pe_raddr),
    .rdata_o(pe_rdata)
  );

  // Riders-per-floor memory, cleared logically by valid bits.
  logic              rp_we;
  logic [MemAw-1:0]  rp_waddr, rp_raddr;
  logic [5:0]        rp_wdata, rp_rdata, rp_val;
  logic              rp_rvld_q;

  medc_ram #(.Width(6), .Depth(RpfDepth)) u_rpf (
    .clk_i  (clk_i),
    .we_i   (rp_we),
    .waddr_i(rp_waddr),
    .wdata_i(rp_wdata),
    .raddr_i(rp_raddr),
    .rdata_o(rp_rdata)
  );

  assign rp_val = rp_rvld_q ? rp_rdata : 6'd0;

  // Shortcuts for the current car.
  logic [FloorW-1:0] cur;
  logic [Floors-1:0] flags;
  logic [3:0]        e_from, e_to;
  logic [MemAw-1:0]  drop_addr, board_addr;
  assign cur        = floor_q[car_q];
  assign flags      = pick_q[car_q] | drop_q[car_q];
  assign e_from     = pe_rdata[15:12];
  assign e_to       = pe_rdata[11:8];
  assign drop_addr  = {car_q, cur};
  assign board_addr = {car_q, e_to};

  // Shared score unit: distance less bonuses, compared with the best so far.
  logic signed [6:0] score;
  logic              req_up, dir_hit;
  always_comb begin
    req_up  = rto_q > rfrom_q;
    dir_hit = (req_up && head_q[car_q] == HeadUp && cur <= rfrom_q) ||
              (!req_up && head_q[car_q] == HeadDown && cur >= rfrom_q);
    score = (cur > rfrom_q) ? 7'(cur - rfrom_q) : 7'(rfrom_q - cur);
    if (idle_q[car_q]) score = score - 7'(idle_bon_q);
    if (dir_hit) score = score - 7'(dir_bon_q);
  end

  logic last_car;
  assign last_car = (3'(car_q) == ne - 3'd1);

  // Scan floor index and its flag.
  logic [FloorW-1:0] scan_f;
  logic              scan_hit;
  assign scan_f   = scan_q[FloorW-1:0];
  assign scan_hit = flags[scan_f];

  // Sequencer next state and memory controls.
  always_comb begin
    state_d  = state_q;
    pe_we    = 1'b0;
    pe_waddr = {best_q, used_q[best_q][PendW-1:0]};
    pe_wdata = {rfrom_q, rto_q, rid_q};
    pe_raddr = {car_q, rd_q[PendW-1:0]};
    rp_we    = 1'b0;
    rp_waddr = board_addr;
    rp_wdata = (rp_val < 6'd63) ? rp_val + 6'd1 : rp_val;
    rp_raddr = board_addr;
    unique case (state_q)
      StIdle:     if (s_axis_tvalid) state_d = s_axis_tuser ? StScore : StCarStart;
      StScore:    if (last_car) state_d = StQueue;
      StQueue: begin
        if (rfrom_q != rto_q && 5'(rfrom_q) < nf && 5'(rto_q) < nf &&
            used_q[best_q] < UsedW'(PendingDepth)) begin
          pe_we = 1'b1;
        end
        state_d = StCarStart;
      end
      StCarStart: begin
        if (pick_q[car_q][cur]) state_d = StBoardRd;
        else state_d = StDropRd;
      end
      StBoardRd: begin
        if (rd_q >= used_q[car_q]) state_d = StDropRd;
        else state_d = StBoardChk;
      end
      StBoardChk: begin
        // Memory data is now valid for entry rd_q - 1; a boarding rider reads its count.
        if (e_from == cur) begin
          state_d = StBoardWr;
        end else begin
          pe_we    = 1'b1;
          pe_waddr = {car_q, wr_q[PendW-1:0]};
          pe_wdata = pe_rdata;
          state_d  = StBoardRd;
        end
      end
      StBoardWr: begin
        // The destination count read last cycle is bumped and written back.
        rp_we    = 1'b1;
        rp_waddr = {car_q, bto_q};
        state_d  = StBoardRd;
      end
      StDropRd: begin
        rp_raddr = drop_addr;
        state_d  = drop_q[car_q][cur] ? StDropWr : StScan;
      end
      StDropWr:   state_d = StScan;
      StScan: begin
        if (found_q || scan_pass_q) state_d = StOut;
      end
      StOut:      if (m_axis_tready) state_d = last_car ? StIdle : StCarStart;
      default:    state_d = StIdle;
    endcase
  end

  // Rider count read tracking: whether the address read last cycle held a valid count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_rvld_q <= 1'b0;
    end else begin
      rp_rvld_q <= rpf_vld_q[rp_raddr] && !(rp_we && rp_waddr == rp_raddr);
    end
  end

  // Next stop decision after the scan.
  logic [FloorW-1:0] nstop;
  assign nstop = ns_q;

  // Main sequencer registers and car state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      car_q       <= '0;
      best_q      <= '0;
      best_s_q    <= '0;
      rvalid_q    <= 1'b0;
      taken_q     <= 1'b0;
      rfrom_q     <= '0;
      rto_q       <= '0;
      rid_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      motion_q    <= MotIdle;
      boarded_q   <= '0;
      left_q      <= '0;
      scan_q      <= '0;
      scan_dir_q  <= 1'b0;
      scan_pass_q <= 1'b0;
      found_q     <= 1'b0;
      ns_q        <= '0;
      bto_q       <= '0;
      rpf_vld_q   <= '0;
      for (int i = 0; i < Elevators; i++) begin
        floor_q[i]  <= '0;
        head_q[i]   <= HeadNone;
        idle_q[i]   <= 1'b1;
        aboard_q[i] <= '0;
        pick_q[i]   <= '0;
        drop_q[i]   <= '0;
        used_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (rp_we) rpf_vld_q[rp_waddr] <= 1'b1;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            rfrom_q  <= s_axis_tdata[3:0];
            rto_q    <= s_axis_tdata[7:4];
            rid_q    <= s_axis_tdata[15:8];
            rvalid_q <= s_axis_tuser;
            taken_q  <= 1'b0;
            best_q   <= '0;
            car_q    <= '0;
          end
        end
        StScore: begin
          if (car_q == '0 || score < best_s_q) begin
            best_s_q <= score;
            best_q   <= car_q;
          end
          car_q <= last_car ? '0 : car_q + 1'b1;
        end
        StQueue: begin
          if (pe_we) begin
            pick_q[best_q][rfrom_q] <= 1'b1;
            used_q[best_q]          <= used_q[best_q] + 1'b1;
            taken_q                 <= 1'b1;
          end
        end
        StCarStart: begin
          motion_q    <= (flags[cur]) ? MotDoor : MotIdle;
          boarded_q   <= '0;
          left_q      <= '0;
          rd_q        <= '0;
          wr_q        <= '0;
          if (pick_q[car_q][cur]) pick_q[car_q][cur] <= 1'b0;
          if (flags[cur]) idle_q[car_q] <= 1'b1;
        end
        StBoardRd: begin
          if (rd_q >= used_q[car_q]) used_q[car_q] <= wr_q;
          else rd_q <= rd_q + 1'b1;
        end
        StBoardChk: begin
          if (e_from == cur) begin
            bto_q <= e_to;
            drop_q[car_q][e_to] <= 1'b1;
            if (aboard_q[car_q] < 6'd63) aboard_q[car_q] <= aboard_q[car_q] + 6'd1;
            boarded_q <= boarded_q + 5'd1;
          end else begin
            wr_q <= wr_q + 1'b1;
          end
        end
        StDropRd: begin
          // Scan setup: own floor first, then by heading.
          found_q     <= 1'b0;
          scan_pass_q <= 1'b0;
          if (head_q[car_q] == HeadUp) begin
            scan_dir_q <= 1'b0;
            scan_q     <= 5'(cur) + 5'd1;
          end else if (head_q[car_q] == HeadDown) begin
            scan_dir_q <= 1'b1;
            scan_q     <= 5'(cur) - 5'd1;
          end else begin
            scan_dir_q <= 1'b0;
            scan_q     <= '0;
          end
        end
        StDropWr: begin
          drop_q[car_q][cur] <= 1'b0;
          left_q             <= rp_val;
          aboard_q[car_q]    <= (aboard_q[car_q] > rp_val) ? aboard_q[car_q] - rp_val : 6'd0;
          rpf_vld_q[drop_addr] <= 1'b0;
        end
        StScan: begin
          if (flags[cur]) begin
            found_q <= 1'b1;
            ns_q    <= cur;
          end else if (!found_q && !scan_pass_q) begin
            if (!scan_dir_q) begin
              if (scan_q < nf && scan_q < 5'(Floors)) begin
                if (scan_hit) begin
                  found_q <= 1'b1;
                  ns_q    <= scan_f;
                end else begin
                  scan_q <= scan_q + 5'd1;
                end
              end else if (head_q[car_q] == HeadUp) begin
                scan_dir_q <= 1'b1;
                scan_q     <= 5'(cur) - 5'd1;
                if (cur == '0) scan_pass_q <= 1'b1;
              end else begin
                scan_pass_q <= 1'b1;
              end
            end else begin
              if (scan_q[4] == 1'b0) begin
                if (scan_hit && 5'(scan_f) < 5'(Floors)) begin
                  found_q <= 1'b1;
                  ns_q    <= scan_f;
                end else if (scan_q == 5'd0) begin
                  if (head_q[car_q] == HeadDown) begin
                    scan_dir_q <= 1'b0;
                    scan_q     <= 5'(cur) + 5'd1;
                  end else begin
                    scan_pass_q <= 1'b1;
                  end
                end else begin
                  scan_q <= scan_q - 5'd1;
                end
              end else if (head_q[car_q] == HeadDown) begin
                scan_dir_q <= 1'b0;
                scan_q     <= 5'(cur) + 5'd1;
              end else begin
                scan_pass_q <= 1'b1;
              end
            end
          end
          // Once the scan has ended, move one floor toward the stop, stay at it, or go idle.
          if (state_d == StOut) begin
            if (!found_q && !(flags[cur])) begin
              idle_q[car_q] <= 1'b1;
              head_q[car_q] <= HeadNone;
            end else if (nstop > cur && found_q) begin
              head_q[car_q]  <= HeadUp;
              idle_q[car_q]  <= 1'b0;
              floor_q[car_q] <= cur + 1'b1;
              if (motion_q == MotIdle) motion_q <= MotUp;
            end else if (nstop < cur && found_q) begin
              head_q[car_q]  <= HeadDown;
              idle_q[car_q]  <= 1'b0;
              floor_q[car_q] <= cur - 1'b1;
              if (motion_q == MotIdle) motion_q <= MotDown;
            end
          end
        end
        StOut: begin
          if (m_axis_tready && !last_car) car_q <= car_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result channel.
  logic [1:0] head_out;
  assign head_out      = (head_q[car_q] == HeadUp || head_q[car_q] == HeadDown) ?
                         head_q[car_q] : HeadNone;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {5'd0, left_q, boarded_q, aboard_q[car_q], head_out, motion_q,
                          floor_q[car_q], car_q};
  assign m_axis_tuser  = {taken_q, rvalid_q ? best_q : 2'd0};
  assign m_axis_tlast  = last_car;

`ifndef ASSERT_OFF
  // The input side is never ready while a result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready during result");
  // A request is only taken when the tick carried one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid && m_axis_tuser[2]
                   |-> rvalid_q)
    else $error("request taken without request");
  // Pending fill never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   used_q[car_q] <= UsedW'(PendingDepth))
    else $error("pending overflow");
`endif

endmodule

// File: dv/multi_elevator_dispatch_controller_core_tb.sv
// Testbench for the elevator group dispatcher: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps
module multi_elevator_dispatch_controller_core_tb
  import medc_pkg::*;
();

  // One expected result beat as it appears on the master side.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  user;
    logic        last;
  } car_report_t;

  // Tracks the car group and holds the car reports still to come.
  class dispatch_scoreboard;
    int          cars_cfg, floors_cfg, idle_bon, dir_bon;
    int          floor_at[Elevators], head[Elevators], idle[Elevators], aboard[Elevators];
    bit [15:0]   pickup[Elevators], dropoff[Elevators];
    int          per_floor[Elevators][Floors];
    bit [15:0]   pending[Elevators][PendingDepth];
    int          used[Elevators];
    car_report_t reports_due[$];
    int          mismatches;

    function new();
      cars_cfg = 2; floors_cfg = 6; idle_bon = 5; dir_bon = 3;
      mismatches = 0;
      for (int i = 0; i < Elevators; i++) begin
        floor_at[i] = 0; head[i] = 0; idle[i] = 1; aboard[i] = 0;
        pickup[i] = '0; dropoff[i] = '0; used[i] = 0;
        for (int f = 0; f < Floors; f++) per_floor[i][f] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, int v);
      case (idx)
        RegActElev: cars_cfg = v & 7;
        RegActFlr:  floors_cfg = v & 31;
        RegIdleBon: idle_bon = v & 15;
        default:    dir_bon = v & 15;
      endcase
    endfunction

    function bit stop_at(int c, int f);
      bit [15:0] m;
      if (f < 0 || f >= Floors) return 0;
      m = pickup[c] | dropoff[c];
      return m[f];
    endfunction

    // Next floor to serve: own floor first, then current heading, then the reverse; with no heading, the lowest floor.
    function int target_floor(int c, int nf);
      int cur;
      cur = floor_at[c];
      if (stop_at(c, cur)) return cur;
      if (head[c] == HeadUp) begin
        for (int f = cur + 1; f < nf; f++) if (stop_at(c, f)) return f;
        for (int f = cur - 1; f >= 0; f--) if (stop_at(c, f)) return f;
        return -1;
      end
      if (head[c] == HeadDown) begin
        for (int f = cur - 1; f >= 0; f--) if (stop_at(c, f)) return f;
        for (int f = cur + 1; f < nf; f++) if (stop_at(c, f)) return f;
        return -1;
      end
      for (int f = 0; f < nf; f++) if (stop_at(c, f)) return f;
      return -1;
    endfunction

    // Advances the group by one accepted tick and queues one report per active car.
    function void note_tick(bit v, int from, int to, int id);
      int ne, nf, best, taken, score, bestscore, cur, motion, boarded, left, ns, w, f, t;
      bit up;
      bit [15:0] e;
      car_report_t rep;
      ne = cars_cfg; nf = floors_cfg;
      if (ne < 1) ne = 1;
      if (ne > Elevators) ne = Elevators;
      if (nf < 2) nf = 2;
      if (nf > Floors) nf = Floors;
      best = 0; taken = 0; bestscore = 0;
      if (v) begin
        up = to > from;
        for (int i = 0; i < ne; i++) begin
          cur = floor_at[i];
          score = cur > from ? cur - from : from - cur;
          if (idle[i]) score -= idle_bon;
          if ((up && head[i] == HeadUp && cur <= from) ||
              (!up && head[i] == HeadDown && cur >= from))
            score -= dir_bon;
          if (i == 0 || score < bestscore) begin
            bestscore = score; best = i;
          end
        end
        if (from != to && from < nf && to < nf && used[best] < PendingDepth) begin
          pickup[best][from] = 1'b1;
          pending[best][used[best]] = {from[3:0], to[3:0], id[7:0]};
          used[best]++;
          taken = 1;
        end
      end
      for (int i = 0; i < ne; i++) begin
        cur = floor_at[i];
        motion = MotIdle; boarded = 0; left = 0;
        if (pickup[i][cur] || dropoff[i][cur]) begin
          motion = MotDoor;
          if (pickup[i][cur]) begin
            pickup[i][cur] = 1'b0;
            w = 0;
            for (int r = 0; r < used[i]; r++) begin
              e = pending[i][r];
              f = e[15:12]; t = e[11:8];
              if (f == cur) begin
                dropoff[i][t] = 1'b1;
                if (aboard[i] < 63) aboard[i]++;
                if (per_floor[i][t] < 63) per_floor[i][t]++;
                boarded++;
              end else begin
                pending[i][w] = e;
                w++;
              end
            end
            used[i] = w;
          end
          if (dropoff[i][cur]) begin
            dropoff[i][cur] = 1'b0;
            left = per_floor[i][cur];
            per_floor[i][cur] = 0;
            aboard[i] = aboard[i] > left ? aboard[i] - left : 0;
          end
          idle[i] = 1;
        end
        ns = target_floor(i, nf);
        if (ns < 0) begin
          idle[i] = 1; head[i] = HeadNone;
        end else if (ns > cur) begin
          head[i] = HeadUp; idle[i] = 0; floor_at[i] = cur + 1;
          if (motion == MotIdle) motion = MotUp;
        end else if (ns < cur) begin
          head[i] = HeadDown; idle[i] = 0; floor_at[i] = cur - 1;
          if (motion == MotIdle) motion = MotDown;
        end
        rep.data = '0;
        rep.data[1:0]   = i[1:0];
        rep.data[5:2]   = floor_at[i][3:0];
        rep.data[7:6]   = motion[1:0];
        rep.data[9:8]   = (head[i] == HeadUp || head[i] == HeadDown) ? head[i][1:0] : HeadNone;
        rep.data[15:10] = aboard[i][5:0];
        rep.data[20:16] = boarded[4:0];
        rep.data[26:21] = left[5:0];
        rep.user[1:0]   = v ? best[1:0] : 2'd0;
        rep.user[2]     = taken[0];
        rep.last        = (i == ne - 1);
        reports_due.push_back(rep);
      end
    endfunction

    // Compares one accepted report with the oldest one due, field by field.
    function void check_report(logic [31:0] d, logic [2:0] u, logic l);
      car_report_t exp_r;
      string names[10];
      int lo[10], wd[10];
      logic [31:0] a, x;
      names = '{"car_index", "car_floor", "car_motion", "car_heading", "riders_aboard",
                "riders_boarded", "riders_left", "assigned_car", "request_taken", "last_car"};
      lo = '{0, 2, 6, 8, 10, 16, 21, 27, 29, 30};
      wd = '{2, 4, 2, 2, 6, 5, 6, 2, 1, 1};
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: car report with none due: tdata=%h", d);
        return;
      end
      exp_r = reports_due.pop_front();
      // Bring the tuser and tlast fields into one word for a common field loop.
      a = {1'b0, l, u, d[26:0]};
      x = {1'b0, exp_r.last, exp_r.user, exp_r.data[26:0]};
      if (d[31:27] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: tdata padding not zero: %h", d);
      end
      for (int k = 0; k < 10; k++) begin
        if (((a >> lo[k]) & ((1 << wd[k]) - 1)) !== ((x >> lo[k]) & ((1 << wd[k]) - 1))) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: %s expected %0d got %0d", names[k],
                     (x >> lo[k]) & ((1 << wd[k]) - 1), (a >> lo[k]) & ((1 << wd[k]) - 1));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [4:0]  cfg_data_i;

  dispatch_scoreboard sb;
  int                 cycle_count;

  multi_elevator_dispatch_controller_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Monitor: check reports first, then note the request and any configuration write accepted at this edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_report(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_tick(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4], s_axis_tdata[15:8]);
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_reg(cfg_index_i, cfg_data_i);
  end

  // Receiver: changing stall modes, plus one long hold-off early in the run.
  initial begin
    int mode_left, mode, hold_left;
    bit hold_done;
    m_axis_tready = 1'b0;
    mode_left = 0; mode = 0; hold_left = 0; hold_done = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && cycle_count > 4000) begin
        hold_done = 1; hold_left = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2); mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (mode == 0) m_axis_tready = 1'b1;
      else if (mode == 1) m_axis_tready = $urandom_range(0, 1);
      else m_axis_tready = ($urandom_range(0, 3) == 0);
    end
  end

  // Sender burst state: a gap is taken once the current burst runs out.
  int burst_left;

  task automatic send_tick(bit v, int from, int to, int id);
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end else begin
      @(negedge clk_i);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = v;
    s_axis_tdata  = {id[7:0], to[3:0], from[3:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_tick(int nf);
    int from, to;
    from = $urandom_range(0, nf - 1);
    to   = $urandom_range(0, nf - 1);
    case ($urandom_range(0, 9))
      0: send_tick(0, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255));
      1: send_tick(1, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255));
      2, 3: send_tick(0, from, to, $urandom_range(0, 255));
      default: begin
        if (to == from) to = (from + 1) % nf;
        send_tick(1, from, to, $urandom_range(0, 255));
      end
    endcase
  endtask

  // Waits until every report has arrived and the sequencer has settled.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (sb.reports_due.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, int v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v[4:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_group(int cars, int floors, int ib, int db);
    drain();
    cfg_write(RegActElev, cars);
    cfg_write(RegActFlr, floors);
    cfg_write(RegIdleBon, ib);
    cfg_write(RegDirBon, db);
  endtask

  // Main sequence: directed ticks, then random phases under several settings.
  initial begin
    int cars_set[8], floors_set[8], ib_set[8], db_set[8], nf;
    sb = new();
    cycle_count = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
    cfg_valid_i = 1'b0; cfg_index_i = RegActElev; cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (80) @(negedge clk_i);

    // Directed part at reset settings: extremes and dropped requests.
    send_tick(1, 0, 5, 0);
    send_tick(1, 5, 0, 255);
    send_tick(0, 15, 15, 255);
    send_tick(1, 3, 3, 17);
    send_tick(1, 15, 0, 1);
    send_tick(1, 0, 15, 2);
    for (int k = 0; k < 6; k++) send_tick(0, 0, 0, 0);
    send_tick(1, 2, 4, 170);
    send_tick(1, 4, 1, 85);
    for (int k = 0; k < 17; k++) send_tick(1, 5, 1, k);
    for (int k = 0; k < 8; k++) send_tick(0, 0, 0, 0);

    cars_set   = '{0, 7, 4, 1, 4, 3, 4, 2};
    floors_set = '{0, 31, 16, 2, 16, 3, 1, 9};
    ib_set     = '{0, 15, 0, 15, 5, 0, 15, 0};
    db_set     = '{0, 15, 0, 0, 3, 15, 15, 0};
    ib_set[7]  = $urandom_range(0, 15);
    db_set[7]  = $urandom_range(0, 15);
    for (int p = 0; p < 8; p++) begin
      set_group(cars_set[p], floors_set[p], ib_set[p], db_set[p]);
      nf = floors_set[p] < 2 ? 2 : (floors_set[p] > 16 ? 16 : floors_set[p]);
      for (int k = 0; k < 36; k++) random_tick(nf);
    end

    drain();
    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (sb.reports_due.size() != 0)
        $display("ERROR: %0d car reports never arrived", sb.reports_due.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/medc_pkg.sv
rtl/medc_ram.sv
rtl/multi_elevator_dispatch_controller_core.sv
dv/multi_elevator_dispatch_controller_core_tb.sv
